[hdl/fifo_with_cancel_and_rate_fare_assert.svh]
// Assertion helpers for the booking queue.
// Define ASSERT_OFF to compile them out.
`ifndef FIFO_WITH_CANCEL_AND_RATE_FARE_ASSERT_SVH
`define FIFO_WITH_CANCEL_AND_RATE_FARE_ASSERT_SVH
`ifndef ASSERT_OFF
`define FCR_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define FCR_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define FCR_ASSERT(lbl, ck, rs, prop, msg)
`define FCR_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

[hdl/fcr_pkg.sv]
package fcr_pkg;

  // queue size and derived widths
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // field widths
  localparam int MODE_W   = 2;
  localparam int ID_W     = 16;
  localparam int TYPE_W   = 4;
  localparam int DIST_W   = 16;
  localparam int STATUS_W = 2;
  localparam int CHARGE_W = 24;
  localparam int RATE_W   = 8;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_STANDARD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_SEDAN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_SUV      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LUXURY   = 3'd3;

  // rate reset values
  localparam logic [RATE_W-1:0] RATE_STANDARD_RST = 8'd10;
  localparam logic [RATE_W-1:0] RATE_SEDAN_RST    = 8'd15;
  localparam logic [RATE_W-1:0] RATE_SUV_RST      = 8'd20;
  localparam logic [RATE_W-1:0] RATE_LUXURY_RST   = 8'd30;

  // vehicle type codes with a rate of their own
  localparam logic [TYPE_W-1:0] TYPE_STANDARD = 4'd1;
  localparam logic [TYPE_W-1:0] TYPE_SEDAN    = 4'd2;
  localparam logic [TYPE_W-1:0] TYPE_SUV      = 4'd3;
  localparam logic [TYPE_W-1:0] TYPE_LUXURY   = 4'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_VIEW   = 2'd1,
    MODE_POP    = 2'd2,
    MODE_CANCEL = 2'd3
  } mode_t;

  // which result the output register loads
  typedef enum logic [2:0] {
    EM_ADD_OK = 3'd0,
    EM_FULL   = 3'd1,
    EM_EMPTY  = 3'd2,
    EM_TAKE   = 3'd3,
    EM_VIEW   = 3'd4,
    EM_MISS   = 3'd5
  } emit_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [TYPE_W-1:0]   kind;
    logic [CHARGE_W-1:0] charge;
  } entry_t;

  typedef struct packed {
    logic  latch_in;
    logic  idx_clr;
    logic  idx_inc;
    logic  rd_next;
    logic  wr_add;
    logic  wr_shift;
    logic  fill_inc;
    logic  fill_dec;
    logic  emit;
    emit_t sel;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty;
    logic  id_match;
    logic  at_end;
    logic  slot_free;
  } dp_status_t;

endpackage

[hdl/fcr_if.sv]
// request channel: one command per transfer
interface fcr_req_if;
  import fcr_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [ID_W-1:0]     entry_id;
  logic [TYPE_W-1:0]   type_code;
  logic [DIST_W-1:0]   distance;

  modport source (output valid, mode, entry_id, type_code, distance, input ready);
  modport sink   (input valid, mode, entry_id, type_code, distance, output ready);
endinterface

// result channel: one result item per transfer
interface fcr_res_if;
  import fcr_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     out_id;
  logic [TYPE_W-1:0]   out_type;
  logic [CHARGE_W-1:0] charge;
  logic                last;

  modport source (output valid, status, out_id, out_type, charge, last, input ready);
  modport sink   (input valid, status, out_id, out_type, charge, last, output ready);
endinterface

[hdl/fcr_ctrl.sv]
module fcr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  fcr_pkg::dp_status_t stat,
  output fcr_pkg::dp_cmd_t    cmd
);
  import fcr_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DECODE   = 12'b0000_0000_0010,
    S_ADD      = 12'b0000_0000_0100,
    S_EMPTY    = 12'b0000_0000_1000,
    S_MISS     = 12'b0000_0001_0000,
    S_VIEW_RD  = 12'b0000_0010_0000,
    S_VIEW_EM  = 12'b0000_0100_0000,
    S_FIND_RD  = 12'b0000_1000_0000,
    S_FIND_CMP = 12'b0001_0000_0000,
    S_TAKE     = 12'b0010_0000_0000,
    S_SH_RD    = 12'b0100_0000_0000,
    S_SH_WR    = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = EM_ADD_OK;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch_in = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_next   = S_DECODE;
        end
      end
      // index is now zero: the head entry is read this cycle
      S_DECODE: begin
        case (stat.mode)
          MODE_ADD:    state_next = S_ADD;
          MODE_VIEW:   state_next = stat.empty ? S_EMPTY : S_VIEW_EM;
          MODE_POP:    state_next = stat.empty ? S_EMPTY : S_TAKE;
          MODE_CANCEL: state_next = stat.empty ? S_MISS : S_FIND_CMP;
          default:     state_next = S_IDLE;
        endcase
      end
      S_ADD: begin
        if (stat.slot_free) begin
          cmd.emit = 1'b1;
          if (stat.full) begin
            cmd.sel = EM_FULL;
          end else begin
            cmd.sel      = EM_ADD_OK;
            cmd.wr_add   = 1'b1;
            cmd.fill_inc = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (stat.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = EM_EMPTY;
          state_next = S_IDLE;
        end
      end
      S_MISS: begin
        if (stat.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = EM_MISS;
          state_next = S_IDLE;
        end
      end
      S_VIEW_RD: state_next = S_VIEW_EM;
      S_VIEW_EM: begin
        if (stat.slot_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_VIEW;
          if (stat.at_end) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_VIEW_RD;
          end
        end
      end
      S_FIND_RD: state_next = S_FIND_CMP;
      S_FIND_CMP: begin
        if (stat.id_match) begin
          state_next = S_TAKE;
        end else if (stat.at_end) begin
          state_next = S_MISS;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_FIND_RD;
        end
      end
      S_TAKE: begin
        if (stat.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = EM_TAKE;
          state_next = S_SH_RD;
        end
      end
      // close the gap: move the entry behind down by one
      S_SH_RD: begin
        if (stat.at_end) begin
          cmd.fill_dec = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.rd_next = 1'b1;
          state_next  = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_SH_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hdl/fcr_datapath.sv]
module fcr_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  fcr_pkg::dp_cmd_t                cmd,
  output fcr_pkg::dp_status_t             stat,
  input  logic [fcr_pkg::MODE_W-1:0]      req_mode,
  input  logic [fcr_pkg::ID_W-1:0]        req_id,
  input  logic [fcr_pkg::TYPE_W-1:0]      req_type,
  input  logic [fcr_pkg::DIST_W-1:0]      req_dist,
  input  logic                            cfg_wr_en,
  input  logic [fcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcr_pkg::RATE_W-1:0]      cfg_data,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [fcr_pkg::STATUS_W-1:0]    res_status,
  output logic [fcr_pkg::ID_W-1:0]        res_id,
  output logic [fcr_pkg::TYPE_W-1:0]      res_type,
  output logic [fcr_pkg::CHARGE_W-1:0]    res_charge,
  output logic                            res_last
);
  import fcr_pkg::*;

  logic [RATE_W-1:0]   rate_standard, rate_sedan, rate_suv, rate_luxury;
  logic [RATE_W-1:0]   rate_sel;
  mode_t               mode;
  logic [ID_W-1:0]     id;
  logic [TYPE_W-1:0]   kind;
  logic [DIST_W-1:0]   distance;
  logic [CNT_W-1:0]    fill;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    rd_addr;
  logic [CHARGE_W-1:0] product;
  entry_t              mem [DEPTH];
  entry_t              rd_data;
  entry_t              new_entry;

  // rate registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_standard <= RATE_STANDARD_RST;
      rate_sedan    <= RATE_SEDAN_RST;
      rate_suv      <= RATE_SUV_RST;
      rate_luxury   <= RATE_LUXURY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RATE_STANDARD: rate_standard <= cfg_data;
        CFG_RATE_SEDAN:    rate_sedan    <= cfg_data;
        CFG_RATE_SUV:      rate_suv      <= cfg_data;
        CFG_RATE_LUXURY:   rate_luxury   <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured command
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      mode     <= mode_t'(req_mode);
      id       <= req_id;
      kind     <= req_type;
      distance <= req_dist;
    end
  end

  // unknown types fall back to the standard rate
  always_comb begin
    case (kind)
      TYPE_SEDAN:  rate_sel = rate_sedan;
      TYPE_SUV:    rate_sel = rate_suv;
      TYPE_LUXURY: rate_sel = rate_luxury;
      default:     rate_sel = rate_standard;
    endcase
  end

  assign product   = CHARGE_W'(distance) * CHARGE_W'(rate_sel);
  assign new_entry = '{id: id, kind: kind, charge: product};

  // fill count and walk index
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      idx  <= '0;
    end else begin
      if (cmd.fill_inc) begin
        fill <= fill + CNT_W'(1);
      end else if (cmd.fill_dec) begin
        fill <= fill - CNT_W'(1);
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  // entry store: one write port, one registered read port
  assign rd_addr = cmd.rd_next ? (idx + IDX_W'(1)) : idx;

  always_ff @(posedge clk) begin
    if (cmd.wr_add) begin
      mem[fill[IDX_W-1:0]] <= new_entry;
    end else if (cmd.wr_shift) begin
      mem[idx] <= rd_data;
    end
    rd_data <= mem[rd_addr];
  end

  // status to the controller
  assign stat.mode      = mode;
  assign stat.full      = (fill == CNT_W'(DEPTH));
  assign stat.empty     = (fill == '0);
  assign stat.id_match  = (rd_data.id == id);
  assign stat.at_end    = ((CNT_W'(idx) + CNT_W'(1)) >= fill);
  assign stat.slot_free = !res_valid || res_ready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.sel)
        EM_ADD_OK: begin
          res_status <= ST_OK;
          res_id     <= id;
          res_type   <= kind;
          res_charge <= product;
          res_last   <= 1'b1;
        end
        EM_FULL: begin
          res_status <= ST_FULL;
          res_id     <= id;
          res_type   <= kind;
          res_charge <= '0;
          res_last   <= 1'b1;
        end
        EM_EMPTY: begin
          res_status <= ST_EMPTY;
          res_id     <= '0;
          res_type   <= '0;
          res_charge <= '0;
          res_last   <= 1'b1;
        end
        EM_TAKE: begin
          res_status <= ST_OK;
          res_id     <= rd_data.id;
          res_type   <= rd_data.kind;
          res_charge <= rd_data.charge;
          res_last   <= 1'b1;
        end
        EM_VIEW: begin
          res_status <= ST_OK;
          res_id     <= rd_data.id;
          res_type   <= rd_data.kind;
          res_charge <= rd_data.charge;
          res_last   <= stat.at_end;
        end
        EM_MISS: begin
          res_status <= ST_NOTFOUND;
          res_id     <= id;
          res_type   <= '0;
          res_charge <= '0;
          res_last   <= 1'b1;
        end
        default: begin
          res_status <= ST_OK;
          res_id     <= '0;
          res_type   <= '0;
          res_charge <= '0;
          res_last   <= 1'b1;
        end
      endcase
    end
  end

endmodule

[hdl/fifo_with_cancel_and_rate_fare.sv]
// Ordered booking queue with per-type fare charging.
// request: mode (add, view, pop, cancel), entry_id, type_code, distance.
// result:  status, out_id, out_type, charge, last; every command gives one
//          result with last set, except a view of a non-empty queue, which
//          gives one result per stored entry, head first, last on the final one.
// cfg:     cfg_wr_en/cfg_index/cfg_data write the four rate registers; other
//          indexes are ignored. The user must write them only while the block
//          is idle; the block itself does not enforce this.
// One command at a time: request.ready is high only between commands.
// View reads the entries in order from the head. Cancel compares the entries
// in order from the head and reports a hit after its compare, or not found
// after the last compare. Pop and cancel then close the gap by moving each
// entry behind the removed one down by one, paced by the single read port of
// the entry store; the block takes no new command until this ends.
// Reset (rst, synchronous) empties the queue and restores the default rates.
// A stalled result waits in the output register; the next command is still
// taken, and the block holds its own next result until the register frees.
`include "fifo_with_cancel_and_rate_fare_assert.svh"

module fifo_with_cancel_and_rate_fare (
  input  logic                          clk,
  input  logic                          rst,
  fcr_req_if.sink                       request,
  fcr_res_if.source                     result,
  input  logic                          cfg_wr_en,
  input  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fcr_pkg::RATE_W-1:0]    cfg_data
);
  import fcr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;
  logic       req_ready;

  assign request.ready = req_ready;

  fcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fcr_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_mode   (request.mode),
    .req_id     (request.entry_id),
    .req_type   (request.type_code),
    .req_dist   (request.distance),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_status (result.status),
    .res_id     (result.out_id),
    .res_type   (result.out_type),
    .res_charge (result.charge),
    .res_last   (result.last)
  );

  // checks
  `FCR_ASSERT(a_emit_free, clk, rst, cmd.emit |-> stat.slot_free, "result register overwritten")
  `FCR_ASSERT(a_add_room, clk, rst, cmd.fill_inc |-> !stat.full, "append to a full queue")
  `FCR_ASSERT(a_drop_nonempty, clk, rst, cmd.fill_dec |-> !stat.empty, "removal from empty queue")
  `FCR_ASSERT_NEXT(a_one_cmd, clk, rst, request.valid && request.ready, !request.ready, "second command taken while busy")

endmodule
